// ----- hdl/oadc_pkg.sv -----
// Package for the drive-mode controller: request, motor command and mode codes,
// word, state and configuration structs, and register reset values.
// No dependencies.
`default_nettype none

package oadc_pkg;

    localparam int unsigned REG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0]  CRUISE_SPEED_RST = 8'd128;
    localparam logic [15:0] REVERSE_MS_RST   = 16'd500;
    localparam logic [15:0] PIVOT_MS_RST     = 16'd1000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CRUISE_SPEED = 2'd0,
        REG_REVERSE_MS   = 2'd1,
        REG_PIVOT_MS     = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        REQ_TICK   = 4'd0,
        REQ_START  = 4'd1,
        REQ_STOP   = 4'd2,
        REQ_ESTOP  = 4'd3,
        REQ_RESET  = 4'd4,
        REQ_FWD    = 4'd5,
        REQ_BACK   = 4'd6,
        REQ_TURN   = 4'd7,
        REQ_PIVOT  = 4'd8
    } req_t;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_STOP     = 3'd1,
        CMD_FORWARD  = 3'd2,
        CMD_BACKWARD = 3'd3,
        CMD_PIVOT    = 3'd4,
        CMD_TURN     = 3'd5,
        CMD_BRAKE    = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_DRIVING  = 2'd1,
        MODE_AVOIDING = 2'd2,
        MODE_STOPPED  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [3:0]          req_type;
        logic [31:0]         now_ms;
        logic                obstacle_seen;
        logic [7:0]          manual_speed;
        logic signed [15:0]  turn_degrees;
        logic                pivot_clockwise;
    } in_word_t;

    typedef struct packed {
        logic [2:0]          motor_cmd;
        logic [7:0]          motor_speed;
        logic                motor_clockwise;
        logic signed [15:0]  motor_degrees;
        logic                accepted;
        logic [1:0]          mode_now;
        logic                moving;
    } out_word_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] mode_start_ms;
        logic        turn_dir;
    } ctrl_state_t;

    typedef struct packed {
        logic [7:0]  cruise_speed;
        logic [15:0] reverse_time_ms;
        logic [15:0] pivot_time_ms;
    } cfg_t;

endpackage : oadc_pkg

`default_nettype wire

// ----- hdl/oadc_in_stage.sv -----
// Input register stage: captures one request word and holds it until the
// step logic moves it on. Depends on oadc_pkg.
`default_nettype none

module oadc_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire oadc_pkg::in_word_t in_word,
    input  wire logic              take,
    output logic                   word_valid,
    output oadc_pkg::in_word_t     word
);

    logic               valid_reg, valid_next;
    oadc_pkg::in_word_t word_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= in_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule : oadc_in_stage

`default_nettype wire

// ----- hdl/oadc_step.sv -----
// Combinational step of the drive-mode controller: result word and next
// state from one request word, the current state and the registers.
// Depends on oadc_pkg.
`default_nettype none

module oadc_step (
    input  wire oadc_pkg::in_word_t    word,
    input  wire oadc_pkg::ctrl_state_t st,
    input  wire oadc_pkg::cfg_t        cfg,
    output oadc_pkg::out_word_t        res,
    output oadc_pkg::ctrl_state_t      st_next
);

    logic [31:0]        elapsed;
    logic [16:0]        bound;
    logic               in_reverse;
    logic               in_pivot;
    oadc_pkg::cmd_t     cmd;
    logic [7:0]         spd;
    logic               cw;
    logic signed [15:0] deg;
    logic               acc;
    oadc_pkg::mode_t    mode_new;
    logic               mode_chg;
    logic               tog;

    // wrapping subtraction; phase bound kept at 17 bits
    assign elapsed    = word.now_ms - st.mode_start_ms;
    assign bound      = {1'b0, cfg.reverse_time_ms} + {1'b0, cfg.pivot_time_ms};
    assign in_reverse = elapsed < {16'd0, cfg.reverse_time_ms};
    assign in_pivot   = elapsed < {15'd0, bound};

    always_comb begin
        cmd      = oadc_pkg::CMD_NONE;
        spd      = 8'd0;
        cw       = 1'b0;
        deg      = 16'sd0;
        acc      = 1'b0;
        mode_new = st.mode;
        mode_chg = 1'b0;
        tog      = 1'b0;
        case (word.req_type)
            oadc_pkg::REQ_TICK: begin
                if (st.mode == oadc_pkg::MODE_DRIVING) begin
                    if (word.obstacle_seen) begin
                        cmd      = oadc_pkg::CMD_STOP;
                        mode_new = oadc_pkg::MODE_AVOIDING;
                        mode_chg = 1'b1;
                        tog      = 1'b1;
                    end else begin
                        cmd = oadc_pkg::CMD_FORWARD;
                        spd = cfg.cruise_speed;
                    end
                end else if (st.mode == oadc_pkg::MODE_AVOIDING) begin
                    if (in_reverse) begin
                        cmd = oadc_pkg::CMD_BACKWARD;
                        spd = {1'b0, cfg.cruise_speed[7:1]};
                    end else if (in_pivot) begin
                        cmd = oadc_pkg::CMD_PIVOT;
                        spd = cfg.cruise_speed;
                        cw  = st.turn_dir;
                    end else begin
                        cmd      = oadc_pkg::CMD_FORWARD;
                        spd      = cfg.cruise_speed;
                        mode_new = oadc_pkg::MODE_DRIVING;
                        mode_chg = 1'b1;
                    end
                end
            end
            oadc_pkg::REQ_START: begin
                if (st.mode == oadc_pkg::MODE_IDLE) begin
                    cmd      = oadc_pkg::CMD_FORWARD;
                    spd      = cfg.cruise_speed;
                    mode_new = oadc_pkg::MODE_DRIVING;
                    mode_chg = 1'b1;
                end
            end
            oadc_pkg::REQ_STOP: begin
                if (st.mode != oadc_pkg::MODE_STOPPED) begin
                    cmd      = oadc_pkg::CMD_STOP;
                    mode_new = oadc_pkg::MODE_IDLE;
                    mode_chg = 1'b1;
                end
            end
            oadc_pkg::REQ_ESTOP: begin
                if (st.mode != oadc_pkg::MODE_STOPPED) begin
                    cmd      = oadc_pkg::CMD_BRAKE;
                    mode_new = oadc_pkg::MODE_STOPPED;
                    mode_chg = 1'b1;
                end
            end
            oadc_pkg::REQ_RESET: begin
                if (st.mode == oadc_pkg::MODE_STOPPED) begin
                    mode_new = oadc_pkg::MODE_IDLE;
                    mode_chg = 1'b1;
                end
            end
            oadc_pkg::REQ_FWD, oadc_pkg::REQ_BACK,
            oadc_pkg::REQ_TURN, oadc_pkg::REQ_PIVOT: begin
                // manual commands only run from idle
                if (st.mode == oadc_pkg::MODE_IDLE) begin
                    acc = 1'b1;
                    spd = word.manual_speed;
                    case (word.req_type)
                        oadc_pkg::REQ_FWD:  cmd = oadc_pkg::CMD_FORWARD;
                        oadc_pkg::REQ_BACK: cmd = oadc_pkg::CMD_BACKWARD;
                        oadc_pkg::REQ_TURN: begin
                            cmd = oadc_pkg::CMD_TURN;
                            deg = word.turn_degrees;
                        end
                        default: begin
                            cmd = oadc_pkg::CMD_PIVOT;
                            cw  = word.pivot_clockwise;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        st_next.mode          = mode_new;
        st_next.mode_start_ms = mode_chg ? word.now_ms : st.mode_start_ms;
        st_next.turn_dir      = st.turn_dir ^ tog;
    end

    always_comb begin
        res.motor_cmd       = cmd;
        res.motor_speed     = spd;
        res.motor_clockwise = cw;
        res.motor_degrees   = deg;
        res.accepted        = acc;
        res.mode_now        = mode_new;
        res.moving          = (mode_new == oadc_pkg::MODE_DRIVING) ||
                              (mode_new == oadc_pkg::MODE_AVOIDING);
    end

endmodule : oadc_step

`default_nettype wire

// ----- hdl/obstacle_avoid_drive_controller_core.sv -----
// Drive-mode controller, top level: input stage, step logic, state, registers.
// Path: the request word is registered in the input stage, the result word in the result register.
// Throughput: one word per cycle while m_ready takes the results, single pass from input to result register.
// Reset (aresetn, synchronous): mode idle, start time 0, turn direction 0,
// registers to their defaults, both stages empty.
// Depends on oadc_pkg, oadc_in_stage and oadc_step.
`default_nettype none

module obstacle_avoid_drive_controller_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [oadc_pkg::REG_IDX_W-1:0]       cfg_index,
    input  wire logic [oadc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [3:0]                           s_req_type,
    input  wire logic [31:0]                          s_now_ms,
    input  wire logic                                 s_obstacle_seen,
    input  wire logic [7:0]                           s_manual_speed,
    input  wire logic signed [15:0]                   s_turn_degrees,
    input  wire logic                                 s_pivot_clockwise,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [2:0]                                m_motor_cmd,
    output logic [7:0]                                m_motor_speed,
    output logic                                      m_motor_clockwise,
    output logic signed [15:0]                        m_motor_degrees,
    output logic                                      m_accepted,
    output logic [1:0]                                m_mode_now,
    output logic                                      m_moving
);

    oadc_pkg::in_word_t    s_word;
    oadc_pkg::in_word_t    word;
    logic                  word_valid;
    logic                  advance;
    oadc_pkg::ctrl_state_t st_reg, st_next;
    oadc_pkg::cfg_t        cfg_reg;
    oadc_pkg::out_word_t   res;
    oadc_pkg::out_word_t   out_reg;
    logic                  out_valid_reg, out_valid_next;

    always_comb begin
        s_word.req_type        = s_req_type;
        s_word.now_ms          = s_now_ms;
        s_word.obstacle_seen   = s_obstacle_seen;
        s_word.manual_speed    = s_manual_speed;
        s_word.turn_degrees    = s_turn_degrees;
        s_word.pivot_clockwise = s_pivot_clockwise;
    end

    // word leaves the input stage whenever the result register is free
    assign advance = word_valid && (!out_valid_reg || m_ready);

    oadc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_word    (s_word),
        .take       (advance),
        .word_valid (word_valid),
        .word       (word)
    );

    oadc_step u_step (
        .word    (word),
        .st      (st_reg),
        .cfg     (cfg_reg),
        .res     (res),
        .st_next (st_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cruise_speed    <= oadc_pkg::CRUISE_SPEED_RST;
            cfg_reg.reverse_time_ms <= oadc_pkg::REVERSE_MS_RST;
            cfg_reg.pivot_time_ms   <= oadc_pkg::PIVOT_MS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                oadc_pkg::REG_CRUISE_SPEED: cfg_reg.cruise_speed    <= cfg_wdata[7:0];
                oadc_pkg::REG_REVERSE_MS:   cfg_reg.reverse_time_ms <= cfg_wdata;
                oadc_pkg::REG_PIVOT_MS:     cfg_reg.pivot_time_ms   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.mode          <= oadc_pkg::MODE_IDLE;
            st_reg.mode_start_ms <= 32'd0;
            st_reg.turn_dir      <= 1'b0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_motor_cmd       = out_reg.motor_cmd;
    assign m_motor_speed     = out_reg.motor_speed;
    assign m_motor_clockwise = out_reg.motor_clockwise;
    assign m_motor_degrees   = out_reg.motor_degrees;
    assign m_accepted        = out_reg.accepted;
    assign m_mode_now        = out_reg.mode_now;
    assign m_moving          = out_reg.moving;

`ifndef SYNTHESIS
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(st_reg))
        else $error("controller state changed without a word moving on");

    a_manual_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_mode_now == oadc_pkg::MODE_IDLE)
        else $error("manual command accepted outside idle");

    a_brake_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_motor_cmd == oadc_pkg::CMD_BRAKE
            |-> m_mode_now == oadc_pkg::MODE_STOPPED)
        else $error("brake issued without entering stopped");

    a_mode_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_mode_now == st_reg.mode)
        else $error("reported mode differs from controller state");
`endif

endmodule : obstacle_avoid_drive_controller_core

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench for obstacle_avoid_drive_controller_core: random and directed request words,
// a tracker class that predicts every motor word, and random idling on both channels.
// Depends on oadc_pkg and the core RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import oadc_pkg::*;

    localparam logic [3:0] REQ_UNUSED_LO  = 4'd9;
    localparam logic [3:0] REQ_UNUSED_HI  = 4'd15;
    localparam int unsigned RX_HOLD_CYCLES = 200;
    localparam int unsigned WORDS_PER_PHASE = 75;
    localparam int unsigned NUM_PHASES      = 6;

    // Predicts the motor word for each accepted request and checks results in order.
    class drive_mode_tracker;
        mode_t       mode;
        logic [31:0] start_ms;
        logic        turn_dir;
        logic [7:0]  cruise;
        logic [15:0] rev_ms;
        logic [15:0] piv_ms;
        out_word_t   motor_words_q[$];
        int unsigned errors;
        int unsigned results_seen;
        int unsigned cmd_count[8];

        function new();
            mode     = MODE_IDLE;
            start_ms = '0;
            turn_dir = 1'b0;
            cruise   = CRUISE_SPEED_RST;
            rev_ms   = REVERSE_MS_RST;
            piv_ms   = PIVOT_MS_RST;
            errors   = 0;
            results_seen = 0;
            foreach (cmd_count[i]) cmd_count[i] = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [15:0] val);
            case (idx)
                REG_CRUISE_SPEED: cruise = val[7:0];
                REG_REVERSE_MS:   rev_ms = val;
                REG_PIVOT_MS:     piv_ms = val;
                default: ;
            endcase
        endfunction

        function void enter_mode(mode_t m, logic [31:0] now);
            mode     = m;
            start_ms = now;
        endfunction

        function int unsigned pending();
            return motor_words_q.size();
        endfunction

        function void predict_step(in_word_t w);
            out_word_t   r;
            logic [31:0] elapsed;
            logic [31:0] bound;
            r       = '0;
            elapsed = w.now_ms - start_ms;
            bound   = 32'(rev_ms) + 32'(piv_ms);   // no wrap: 17 bits are enough
            case (w.req_type)
                REQ_TICK: begin
                    if (mode == MODE_DRIVING) begin
                        if (w.obstacle_seen) begin
                            r.motor_cmd = CMD_STOP;
                            enter_mode(MODE_AVOIDING, w.now_ms);
                            turn_dir = ~turn_dir;
                        end else begin
                            r.motor_cmd   = CMD_FORWARD;
                            r.motor_speed = cruise;
                        end
                    end else if (mode == MODE_AVOIDING) begin
                        if (elapsed < 32'(rev_ms)) begin
                            r.motor_cmd   = CMD_BACKWARD;
                            r.motor_speed = cruise >> 1;
                        end else if (elapsed < bound) begin
                            r.motor_cmd       = CMD_PIVOT;
                            r.motor_speed     = cruise;
                            r.motor_clockwise = turn_dir;
                        end else begin
                            r.motor_cmd   = CMD_FORWARD;
                            r.motor_speed = cruise;
                            enter_mode(MODE_DRIVING, w.now_ms);
                        end
                    end
                end
                REQ_START: begin
                    if (mode == MODE_IDLE) begin
                        enter_mode(MODE_DRIVING, w.now_ms);
                        r.motor_cmd   = CMD_FORWARD;
                        r.motor_speed = cruise;
                    end
                end
                REQ_STOP: begin
                    if (mode != MODE_STOPPED) begin
                        r.motor_cmd = CMD_STOP;
                        enter_mode(MODE_IDLE, w.now_ms);
                    end
                end
                REQ_ESTOP: begin
                    if (mode != MODE_STOPPED) begin
                        r.motor_cmd = CMD_BRAKE;
                        enter_mode(MODE_STOPPED, w.now_ms);
                    end
                end
                REQ_RESET: begin
                    if (mode == MODE_STOPPED) enter_mode(MODE_IDLE, w.now_ms);
                end
                REQ_FWD, REQ_BACK, REQ_TURN, REQ_PIVOT: begin
                    if (mode == MODE_IDLE) begin
                        r.accepted    = 1'b1;
                        r.motor_speed = w.manual_speed;
                        case (w.req_type)
                            REQ_FWD:  r.motor_cmd = CMD_FORWARD;
                            REQ_BACK: r.motor_cmd = CMD_BACKWARD;
                            REQ_TURN: begin
                                r.motor_cmd     = CMD_TURN;
                                r.motor_degrees = w.turn_degrees;
                            end
                            default: begin
                                r.motor_cmd       = CMD_PIVOT;
                                r.motor_clockwise = w.pivot_clockwise;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
            r.mode_now = mode;
            r.moving   = (mode == MODE_DRIVING) || (mode == MODE_AVOIDING);
            cmd_count[r.motor_cmd]++;
            motor_words_q.push_back(r);
        endfunction

        function void check_field(string field, logic signed [31:0] want,
                                  logic signed [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void match_result(out_word_t got);
            out_word_t want;
            if (motor_words_q.size() == 0) begin
                $error("result word with nothing expected: cmd %0d mode %0d",
                       got.motor_cmd, got.mode_now);
                errors++;
                return;
            end
            want = motor_words_q.pop_front();
            results_seen++;
            check_field("motor_cmd",       want.motor_cmd,       got.motor_cmd);
            check_field("motor_speed",     want.motor_speed,     got.motor_speed);
            check_field("motor_clockwise", want.motor_clockwise, got.motor_clockwise);
            check_field("motor_degrees",   want.motor_degrees,   got.motor_degrees);
            check_field("accepted",        want.accepted,        got.accepted);
            check_field("mode_now",        want.mode_now,        got.mode_now);
            check_field("moving",          want.moving,          got.moving);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [3:0]            s_req_type;
    logic [31:0]           s_now_ms;
    logic                  s_obstacle_seen;
    logic [7:0]            s_manual_speed;
    logic signed [15:0]    s_turn_degrees;
    logic                  s_pivot_clockwise;
    logic                  m_valid;
    logic                  m_ready;
    logic [2:0]            m_motor_cmd;
    logic [7:0]            m_motor_speed;
    logic                  m_motor_clockwise;
    logic signed [15:0]    m_motor_degrees;
    logic                  m_accepted;
    logic [1:0]            m_mode_now;
    logic                  m_moving;

    drive_mode_tracker tracker;
    bit                tx_steady;
    bit                rx_steady;
    bit                rx_hold;
    logic [31:0]       clock_ms;
    int unsigned       words_sent;
    int unsigned       settings_used;

    obstacle_avoid_drive_controller_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_now_ms          (s_now_ms),
        .s_obstacle_seen   (s_obstacle_seen),
        .s_manual_speed    (s_manual_speed),
        .s_turn_degrees    (s_turn_degrees),
        .s_pivot_clockwise (s_pivot_clockwise),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_motor_cmd       (m_motor_cmd),
        .m_motor_speed     (m_motor_speed),
        .m_motor_clockwise (m_motor_clockwise),
        .m_motor_degrees   (m_motor_degrees),
        .m_accepted        (m_accepted),
        .m_mode_now        (m_mode_now),
        .m_moving          (m_moving)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic in_word_t rand_word();
        return in_word_t'({$urandom, $urandom});
    endfunction

    function automatic in_word_t mk_word(logic [3:0] req, logic [31:0] now, logic obst,
                                         logic [7:0] spd, logic signed [15:0] deg,
                                         logic cw);
        in_word_t w;
        w.req_type        = req;
        w.now_ms          = now;
        w.obstacle_seen   = obst;
        w.manual_speed    = spd;
        w.turn_degrees    = deg;
        w.pivot_clockwise = cw;
        return w;
    endfunction

    // Mostly well-formed traffic for the current mode; a share of pure noise.
    function automatic in_word_t next_word();
        in_word_t    w;
        int unsigned pick;
        logic [31:0] bound;
        logic [31:0] off;
        w        = rand_word();
        pick     = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, 40);
        if (pick < 8) return w;
        w.now_ms = clock_ms;
        case (tracker.mode)
            MODE_IDLE: begin
                if (pick < 45)      w.req_type = REQ_START;
                else if (pick < 75) w.req_type = 4'($urandom_range(REQ_FWD, REQ_PIVOT));
                else if (pick < 84) w.req_type = REQ_TICK;
                else if (pick < 91) w.req_type = REQ_ESTOP;
                else                w.req_type = 4'($urandom_range(REQ_STOP, REQ_UNUSED_HI));
            end
            MODE_DRIVING: begin
                if (pick < 72) begin
                    w.req_type      = REQ_TICK;
                    w.obstacle_seen = ($urandom_range(0, 3) == 0);
                end else if (pick < 80) w.req_type = REQ_STOP;
                else if (pick < 85)     w.req_type = REQ_ESTOP;
                else w.req_type = 4'($urandom_range(REQ_START, REQ_UNUSED_HI));
            end
            MODE_AVOIDING: begin
                if (pick < 88) begin
                    bound = 32'(tracker.rev_ms) + 32'(tracker.piv_ms);
                    case ($urandom_range(0, 6))
                        0, 1, 2: off = $urandom_range(0, bound);
                        3:       off = 32'(tracker.rev_ms) - 1;
                        4:       off = 32'(tracker.rev_ms);
                        5:       off = bound - 1;
                        default: off = bound;
                    endcase
                    w.req_type = REQ_TICK;
                    w.now_ms   = tracker.start_ms + off;
                    clock_ms   = w.now_ms;
                end else w.req_type = 4'($urandom_range(REQ_START, REQ_UNUSED_HI));
            end
            default: begin
                if (pick < 50) w.req_type = REQ_RESET;
                else           w.req_type = 4'($urandom_range(REQ_TICK, REQ_UNUSED_HI));
            end
        endcase
        return w;
    endfunction

    task automatic drive_payload(input in_word_t w);
        s_req_type        <= w.req_type;
        s_now_ms          <= w.now_ms;
        s_obstacle_seen   <= w.obstacle_seen;
        s_manual_speed    <= w.manual_speed;
        s_turn_degrees    <= w.turn_degrees;
        s_pivot_clockwise <= w.pivot_clockwise;
    endtask

    task automatic send_word(input in_word_t w);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_valid <= 1'b0;
            drive_payload(rand_word());
            repeat (gap) @(posedge aclk);
        end
        drive_payload(w);
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        tracker.predict_step(w);
        words_sent++;
    endtask

    // Drops valid and waits until every predicted word has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    task automatic set_drive_cfg(input logic [15:0] cruise_word, input logic [15:0] rev,
                                 input logic [15:0] piv);
        repeat (4) @(posedge aclk);   // let the last word clear the pipe
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CRUISE_SPEED;
        cfg_wdata <= cruise_word;
        @(posedge aclk);
        tracker.set_reg(REG_CRUISE_SPEED, cruise_word);
        cfg_index <= REG_REVERSE_MS;
        cfg_wdata <= rev;
        @(posedge aclk);
        tracker.set_reg(REG_REVERSE_MS, rev);
        cfg_index <= REG_PIVOT_MS;
        cfg_wdata <= piv;
        @(posedge aclk);
        tracker.set_reg(REG_PIVOT_MS, piv);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Receiver: random stall before each word, plus one long hold-off on request.
    initial begin
        int unsigned stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end
            stall = rx_steady ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : result_monitor
        out_word_t got;
        got.motor_cmd       = m_motor_cmd;
        got.motor_speed     = m_motor_speed;
        got.motor_clockwise = m_motor_clockwise;
        got.motor_degrees   = m_motor_degrees;
        got.accepted        = m_accepted;
        got.mode_now        = m_mode_now;
        got.moving          = m_moving;
        if (aresetn && m_valid && m_ready) tracker.match_result(got);
    end

    initial begin
        logic [31:0] t0;
        tracker       = new();
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        rx_hold       = 1'b0;
        words_sent    = 0;
        settings_used = 1;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_CRUISE_SPEED;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        drive_payload('0);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: manual commands in idle, ignored requests, a full avoidance across the wrap
        t0 = 32'hFFFF_FFF0;
        send_word(mk_word(REQ_TICK, 32'd10, 1'b1, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_FWD, 32'd11, 1'b0, 8'd255, 16'sd0, 1'b0));
        send_word(mk_word(REQ_BACK, 32'd12, 1'b0, 8'd0, 16'sd0, 1'b1));
        send_word(mk_word(REQ_TURN, 32'd13, 1'b0, 8'd7, -16'sd32768, 1'b0));
        send_word(mk_word(REQ_TURN, 32'd14, 1'b0, 8'd200, 16'sd32767, 1'b1));
        send_word(mk_word(REQ_PIVOT, 32'd15, 1'b0, 8'd255, 16'sd0, 1'b1));
        send_word(mk_word(REQ_PIVOT, 32'd16, 1'b0, 8'd1, 16'sd0, 1'b0));
        send_word(mk_word(REQ_RESET, 32'd17, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_STOP, 32'd18, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_UNUSED_LO, 32'd19, 1'b1, 8'd9, 16'sd5, 1'b1));
        send_word(mk_word(REQ_UNUSED_HI, 32'hFFFF_FFFF, 1'b1, 8'd9, 16'sd5, 1'b1));
        send_word(mk_word(REQ_START, 32'hFFFF_FF00, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_START, 32'hFFFF_FF01, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_FWD, 32'hFFFF_FF02, 1'b0, 8'd99, 16'sd0, 1'b0));
        send_word(mk_word(REQ_TICK, 32'hFFFF_FF03, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_TICK, t0, 1'b1, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_TICK, t0 + 32'd499, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_TICK, t0 + 32'd500, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_TICK, t0 + 32'd1499, 1'b1, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_TICK, t0 + 32'd1500, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_TICK, t0 + 32'd1600, 1'b1, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_ESTOP, t0 + 32'd1601, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_STOP, t0 + 32'd1602, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_ESTOP, t0 + 32'd1603, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_START, t0 + 32'd1604, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_BACK, t0 + 32'd1605, 1'b0, 8'd50, 16'sd0, 1'b0));
        send_word(mk_word(REQ_RESET, t0 + 32'd1606, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_ESTOP, t0 + 32'd1607, 1'b0, 8'd0, 16'sd0, 1'b0));
        send_word(mk_word(REQ_RESET, t0 + 32'd1608, 1'b0, 8'd0, 16'sd0, 1'b0));
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_drive_cfg({8'($urandom), 8'd255}, 16'd0, 16'd0);
                1: set_drive_cfg(16'd0, 16'hFFFF, 16'hFFFF);
                2: set_drive_cfg(16'($urandom), 16'($urandom_range(0, 300)),
                                 16'($urandom_range(0, 300)));
                3: set_drive_cfg(16'd1, 16'd1, 16'hFFFF);
                4: set_drive_cfg(16'($urandom), 16'hFFFF, 16'd0);
                default: set_drive_cfg({8'($urandom), CRUISE_SPEED_RST}, REVERSE_MS_RST,
                                       PIVOT_MS_RST);
            endcase
            clock_ms  = (ph == 1) ? 32'hFFFF_F000 : $urandom;
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
                if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
                // block the result side while the sender keeps offering back to back
                if (ph == 2 && k == 20) begin
                    rx_hold   = 1'b1;
                    tx_steady = 1'b1;
                end
                if (ph == 3 && k == 40) wait_drained();
                send_word(next_word());
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        $display("summary: %0d request words over %0d register settings, %0d results checked",
                 words_sent, settings_used, tracker.results_seen);
        $display("summary: none %0d stop %0d fwd %0d back %0d pivot %0d turn %0d brake %0d",
                 tracker.cmd_count[CMD_NONE], tracker.cmd_count[CMD_STOP],
                 tracker.cmd_count[CMD_FORWARD], tracker.cmd_count[CMD_BACKWARD],
                 tracker.cmd_count[CMD_PIVOT], tracker.cmd_count[CMD_TURN],
                 tracker.cmd_count[CMD_BRAKE]);
        if (tracker.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
